// ===== rtl/bcr_pkg.sv =====
// ----------------------------------------------------------------------------
// bcr_pkg
// Shared types and constants for the binary region centroid block.
// ----------------------------------------------------------------------------
package bcr_pkg;

	localparam int unsigned PIX_W    = 8;
	localparam int unsigned FW_W     = 12;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 12;
	localparam int unsigned COUNT_W  = 23;
	localparam int unsigned SUM_W    = 33;
	localparam int unsigned COORD_W  = 11;
	localparam int unsigned DIV_STEPS = COORD_W + 1;
	localparam int unsigned STEP_W   = $clog2(DIV_STEPS);

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd1;

	localparam logic [PIX_W-1:0] THRESHOLD_RESET   = 8'd255;
	localparam logic [FW_W-1:0]  FRAME_WIDTH_RESET = 12'd640;

	typedef struct packed {
		logic acc;
		logic load;
		logic step;
	} cmd_t;

endpackage

// ===== rtl/bcr_div.sv =====
// ----------------------------------------------------------------------------
// bcr_div
// Restoring divider, one quotient bit per step, quotient clamped to 11 bits.
// ----------------------------------------------------------------------------
module bcr_div (
	input  logic                          clk,
	input  logic                          load,
	input  logic                          step,
	input  logic [bcr_pkg::SUM_W-1:0]     dividend,
	input  logic [bcr_pkg::COUNT_W-1:0]   divisor,
	output logic [bcr_pkg::COORD_W-1:0]   quotient
);

	logic [bcr_pkg::SUM_W-1:0]   rem_q;
	logic [bcr_pkg::SUM_W:0]     dvs_q;
	logic [bcr_pkg::COORD_W-1:0] quo_q;
	logic                        sat_q;
	logic                        first_q;
	logic                        ge;

	assign ge = {1'b0, rem_q} >= dvs_q;

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q   <= dividend;
			dvs_q   <= {divisor, {bcr_pkg::COORD_W{1'b0}}};
			quo_q   <= '0;
			sat_q   <= 1'b0;
			first_q <= 1'b1;
		end else if (step) begin
			if (ge && !sat_q) begin
				rem_q <= rem_q - dvs_q[bcr_pkg::SUM_W-1:0];
			end
			dvs_q   <= dvs_q >> 1;
			quo_q   <= {quo_q[bcr_pkg::COORD_W-2:0], ge};
			sat_q   <= sat_q | (ge & first_q);
			first_q <= 1'b0;
		end
	end

	assign quotient = sat_q ? {bcr_pkg::COORD_W{1'b1}} : quo_q;

endmodule

// ===== rtl/bcr_datapath.sv =====
// ----------------------------------------------------------------------------
// bcr_datapath
// Configuration registers, raster position counters, moment accumulators
// and the two centroid dividers.
// ----------------------------------------------------------------------------
module bcr_datapath #(
	parameter int unsigned MAX_WIDTH  = 2048,
	parameter int unsigned MAX_HEIGHT = 2048
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bcr_pkg::cmd_t                   cmd,
	input  logic                            wr_en,
	input  logic [bcr_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [bcr_pkg::CFG_DAT_W-1:0]   wr_data,
	input  logic [bcr_pkg::PIX_W-1:0]       pixel_value,
	input  logic                            frame_end,
	output logic                            found,
	output logic [bcr_pkg::COORD_W-1:0]     center_x,
	output logic [bcr_pkg::COORD_W-1:0]     center_y
);

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned RW = $clog2(MAX_HEIGHT);
	localparam int unsigned EW = $clog2(MAX_WIDTH + 1);

	logic [bcr_pkg::PIX_W-1:0]   thresh_q;
	logic [bcr_pkg::FW_W-1:0]    fw_q;
	logic [CW-1:0]               col_q;
	logic [RW-1:0]               row_q;
	logic [bcr_pkg::COUNT_W-1:0] count_q;
	logic [bcr_pkg::SUM_W-1:0]   row_sum_q;
	logic [bcr_pkg::SUM_W-1:0]   col_sum_q;
	logic                        found_q;

	logic [EW-1:0]               eff_w;
	logic                        wrap;
	logic                        hit;
	logic [bcr_pkg::SUM_W:0]     row_add;
	logic [bcr_pkg::SUM_W:0]     col_add;
	logic [bcr_pkg::COORD_W-1:0] qx;
	logic [bcr_pkg::COORD_W-1:0] qy;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= bcr_pkg::THRESHOLD_RESET;
			fw_q     <= bcr_pkg::FRAME_WIDTH_RESET;
		end else if (wr_en) begin
			case (wr_index)
				bcr_pkg::REG_THRESHOLD:   thresh_q <= wr_data[bcr_pkg::PIX_W-1:0];
				bcr_pkg::REG_FRAME_WIDTH: fw_q     <= wr_data[bcr_pkg::FW_W-1:0];
				default: ;
			endcase
		end
	end

	// effective row length
	always_comb begin
		if (fw_q == '0) begin
			eff_w = EW'(1);
		end else if (32'(fw_q) > MAX_WIDTH) begin
			eff_w = EW'(MAX_WIDTH);
		end else begin
			eff_w = EW'(fw_q);
		end
	end

	assign wrap    = ({1'b0, EW'(col_q)} + 1'b1) >= {1'b0, eff_w};
	assign hit     = (pixel_value >= thresh_q) && (count_q != '1);
	assign row_add = {1'b0, row_sum_q} + (bcr_pkg::SUM_W + 1)'(row_q);
	assign col_add = {1'b0, col_sum_q} + (bcr_pkg::SUM_W + 1)'(col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			count_q   <= '0;
			row_sum_q <= '0;
			col_sum_q <= '0;
			found_q   <= 1'b0;
		end else if (cmd.load) begin
			found_q   <= count_q != '0;
			col_q     <= '0;
			row_q     <= '0;
			count_q   <= '0;
			row_sum_q <= '0;
			col_sum_q <= '0;
		end else if (cmd.acc) begin
			if (hit) begin
				count_q   <= count_q + 1'b1;
				row_sum_q <= row_add[bcr_pkg::SUM_W] ? '1 : row_add[bcr_pkg::SUM_W-1:0];
				col_sum_q <= col_add[bcr_pkg::SUM_W] ? '1 : col_add[bcr_pkg::SUM_W-1:0];
			end
			if (!frame_end) begin
				if (wrap) begin
					col_q <= '0;
					if (row_q != RW'(MAX_HEIGHT - 1)) begin
						row_q <= row_q + 1'b1;
					end
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	bcr_div u_div_x (
		.clk      (clk),
		.load     (cmd.load),
		.step     (cmd.step),
		.dividend (col_sum_q),
		.divisor  (count_q),
		.quotient (qx)
	);

	bcr_div u_div_y (
		.clk      (clk),
		.load     (cmd.load),
		.step     (cmd.step),
		.dividend (row_sum_q),
		.divisor  (count_q),
		.quotient (qy)
	);

	assign found    = found_q;
	assign center_x = found_q ? qx : '0;
	assign center_y = found_q ? qy : '0;

endmodule

// ===== rtl/bcr_ctrl.sv =====
// ----------------------------------------------------------------------------
// bcr_ctrl
// Sequencer: accepts pixels, then runs the divide and strobes the result.
// ----------------------------------------------------------------------------
module bcr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          frame_end,
	output logic          busy,
	output logic          done,
	output bcr_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LOAD = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t                      state_q;
	logic [bcr_pkg::STEP_W-1:0]  step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start && frame_end) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == bcr_pkg::STEP_W'(bcr_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy     = state_q != ST_IDLE;
	assign done     = state_q == ST_OUT;
	assign cmd.acc  = (state_q == ST_IDLE) && start;
	assign cmd.load = state_q == ST_LOAD;
	assign cmd.step = state_q == ST_DIV;

endmodule

// ===== rtl/binary_region_centroid.sv =====
// ----------------------------------------------------------------------------
// binary_region_centroid
// Centroid of the thresholded pixels of a raster-ordered mask frame.
// ----------------------------------------------------------------------------
// channel   ports                                  handshake
// request   start, pixel_value, frame_end          taken when start & !busy
// result    done, found, center_x, center_y        valid for the done cycle
// config    wr_en, wr_index, wr_data               written when wr_en
//
// one pixel per cycle while a frame streams in
// a frame-end pixel holds busy through a load of the dividers,
// 12 restoring divide steps (one quotient bit per cycle) and the result state
// reset clears the counters and accumulators and loads threshold 255, width 640
// the result is held one cycle only; the receiver cannot stall it
// ----------------------------------------------------------------------------
module binary_region_centroid #(
	parameter int unsigned MAX_WIDTH  = 2048,
	parameter int unsigned MAX_HEIGHT = 2048
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [bcr_pkg::PIX_W-1:0]       pixel_value,
	input  logic                            frame_end,
	output logic                            done,
	output logic                            found,
	output logic [bcr_pkg::COORD_W-1:0]     center_x,
	output logic [bcr_pkg::COORD_W-1:0]     center_y,
	input  logic                            wr_en,
	input  logic [bcr_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [bcr_pkg::CFG_DAT_W-1:0]   wr_data
);

	bcr_pkg::cmd_t cmd;

	bcr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.frame_end (frame_end),
		.busy      (busy),
		.done      (done),
		.cmd       (cmd)
	);

	bcr_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.pixel_value (pixel_value),
		.frame_end   (frame_end),
		.found       (found),
		.center_x    (center_x),
		.center_y    (center_y)
	);

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the binary region centroid block against an in-bench predictor:
// pixel frames go in through the start/busy port, each frame-end result is
// compared field by field with the centroid the predictor worked out, across
// directed frames, randomly configured phases (some with idle gaps), and a long frame.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int MAX_W  = 2048;
	localparam int MAX_H  = 2048;
	localparam int SETTLE = 20;

	localparam logic [bcr_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [bcr_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef struct packed {
		logic [bcr_pkg::PIX_W-1:0] pix;
		logic                      last;
	} pixel_item_t;

	typedef struct packed {
		logic                        found;
		logic [bcr_pkg::COORD_W-1:0] cx;
		logic [bcr_pkg::COORD_W-1:0] cy;
	} centroid_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic                          busy;
	logic [bcr_pkg::PIX_W-1:0]     pixel_value = '0;
	logic                          frame_end = 1'b0;
	logic                          done;
	logic                          found;
	logic [bcr_pkg::COORD_W-1:0]   center_x;
	logic [bcr_pkg::COORD_W-1:0]   center_y;
	logic                          wr_en = 1'b0;
	logic [bcr_pkg::CFG_IDX_W-1:0] wr_index = '0;
	logic [bcr_pkg::CFG_DAT_W-1:0] wr_data = '0;

	pixel_item_t pixel_q[$];
	centroid_t   centroid_q[$];
	int          idle_pct = 0;
	int          mismatches = 0;

	// predictor state
	logic [bcr_pkg::PIX_W-1:0]   thr_m = bcr_pkg::THRESHOLD_RESET;
	logic [bcr_pkg::FW_W-1:0]    fw_m = bcr_pkg::FRAME_WIDTH_RESET;
	logic [bcr_pkg::COORD_W-1:0] col_m = '0;
	logic [bcr_pkg::COORD_W-1:0] row_m = '0;
	logic [bcr_pkg::COUNT_W-1:0] hits_m = '0;
	logic [bcr_pkg::SUM_W-1:0]   rsum_m = '0;
	logic [bcr_pkg::SUM_W-1:0]   csum_m = '0;

	binary_region_centroid #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pixel_value(pixel_value),
		.frame_end(frame_end),
		.done(done),
		.found(found),
		.center_x(center_x),
		.center_y(center_y),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always #5 clk = ~clk;

	function automatic int eff_width();
		if (fw_m == '0)
			return 1;
		if (fw_m > MAX_W)
			return MAX_W;
		return int'(fw_m);
	endfunction

	function automatic logic [bcr_pkg::COORD_W-1:0] mean_coord(
		input logic [bcr_pkg::SUM_W-1:0] sum);
		logic [bcr_pkg::SUM_W-1:0] q;
		if (hits_m == '0)
			return '0;
		q = sum / (bcr_pkg::SUM_W)'(hits_m);
		if (q > {bcr_pkg::COORD_W{1'b1}})
			return '1;
		return q[bcr_pkg::COORD_W-1:0];
	endfunction

	task automatic accumulate_pixel(input logic [bcr_pkg::PIX_W-1:0] pix, input logic last);
		logic [bcr_pkg::SUM_W:0] rs;
		logic [bcr_pkg::SUM_W:0] cs;
		centroid_t               c;
		if (pix >= thr_m && hits_m != '1) begin
			hits_m = hits_m + 1'b1;
			rs = {1'b0, rsum_m} + (bcr_pkg::SUM_W + 1)'(row_m);
			cs = {1'b0, csum_m} + (bcr_pkg::SUM_W + 1)'(col_m);
			rsum_m = rs[bcr_pkg::SUM_W] ? '1 : rs[bcr_pkg::SUM_W-1:0];
			csum_m = cs[bcr_pkg::SUM_W] ? '1 : cs[bcr_pkg::SUM_W-1:0];
		end
		if (last) begin
			c.found = (hits_m != '0);
			c.cx = mean_coord(csum_m);
			c.cy = mean_coord(rsum_m);
			centroid_q.push_back(c);
			col_m = '0;
			row_m = '0;
			hits_m = '0;
			rsum_m = '0;
			csum_m = '0;
		end else if (int'(col_m) + 1 >= eff_width()) begin
			col_m = '0;
			if (int'(row_m) + 1 < MAX_H)
				row_m = row_m + 1'b1;
		end else begin
			col_m = col_m + 1'b1;
		end
	endtask

	// request driver
	always @(posedge clk) begin : drive_p
		logic taken;
		taken = start && !busy;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (taken) begin
				accumulate_pixel(pixel_q[0].pix, pixel_q[0].last);
				pixel_q.delete(0);
			end
			if (!start || taken) begin
				if (pixel_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					start <= 1'b1;
					pixel_value <= pixel_q[0].pix;
					frame_end <= pixel_q[0].last;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin : check_p
		centroid_t want;
		if (arst_n && done) begin
			if (centroid_q.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: unexpected result found=%0b x=%0d y=%0d",
						$time, found, center_x, center_y);
				mismatches++;
			end else begin
				want = centroid_q.pop_front();
				if (found !== want.found || center_x !== want.cx || center_y !== want.cy) begin
					if (mismatches < 10)
						$display("%0t: expected found=%0b x=%0d y=%0d, got found=%0b x=%0d y=%0d",
							$time, want.found, want.cx, want.cy, found, center_x, center_y);
					mismatches++;
				end
			end
		end
	end

	task automatic reg_write(input logic [bcr_pkg::CFG_IDX_W-1:0] idx,
		input logic [bcr_pkg::CFG_DAT_W-1:0] data);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == bcr_pkg::REG_THRESHOLD)
			thr_m = data[bcr_pkg::PIX_W-1:0];
		else if (idx == bcr_pkg::REG_FRAME_WIDTH)
			fw_m = data[bcr_pkg::FW_W-1:0];
	endtask

	task automatic push_pixel(input logic [bcr_pkg::PIX_W-1:0] pix, input logic last);
		pixel_q.push_back('{pix, last});
	endtask

	task automatic settle();
		while (pixel_q.size() != 0 || centroid_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [bcr_pkg::PIX_W-1:0] make_pixel();
		int v;
		case ($urandom_range(0, 3))
			0: v = int'(thr_m) + int'($urandom_range(0, 4)) - 2;
			1: v = ($urandom_range(0, 1) != 0) ? 255 : 0;
			default: v = $urandom_range(0, 255);
		endcase
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v[bcr_pkg::PIX_W-1:0];
	endfunction

	// frames of random length; the budget may run out mid-frame
	task automatic fill_frames(input int budget);
		int len;
		int w;
		w = eff_width();
		while (budget > 0) begin
			len = (w <= 16) ? $urandom_range(1, 3 * w) : $urandom_range(1, 48);
			for (int i = 0; i < len && budget > 0; i++) begin
				push_pixel(make_pixel(), i == len - 1);
				budget--;
			end
		end
	endtask

	task automatic random_config();
		logic [bcr_pkg::CFG_DAT_W-1:0] t;
		logic [bcr_pkg::CFG_DAT_W-1:0] f;
		t = (bcr_pkg::CFG_DAT_W)'($urandom_range(0, 4095));
		case ($urandom_range(0, 4))
			0: t[bcr_pkg::PIX_W-1:0] = '0;
			1: t[bcr_pkg::PIX_W-1:0] = '1;
			default: ;
		endcase
		case ($urandom_range(0, 7))
			0: f = '0;
			1: f = 12'd2048;
			2: f = (bcr_pkg::CFG_DAT_W)'($urandom_range(2049, 4095));
			3: f = (bcr_pkg::CFG_DAT_W)'($urandom_range(17, 2047));
			default: f = (bcr_pkg::CFG_DAT_W)'($urandom_range(1, 16));
		endcase
		if ($urandom_range(0, 1) != 0) begin
			reg_write(bcr_pkg::REG_THRESHOLD, t);
			reg_write(bcr_pkg::REG_FRAME_WIDTH, f);
		end else begin
			reg_write(bcr_pkg::REG_FRAME_WIDTH, f);
			reg_write(bcr_pkg::REG_THRESHOLD, t);
		end
		if ($urandom_range(0, 2) == 0)
			reg_write(($urandom_range(0, 1) != 0) ? REG_SPARE_3 : REG_SPARE_2,
				(bcr_pkg::CFG_DAT_W)'($urandom_range(0, 4095)));
	endtask

	initial begin : stim_p
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: single-pixel hit, empty frame, two hits in row 0
		push_pixel(8'hFF, 1'b1);
		push_pixel(8'hFE, 1'b1);
		push_pixel(8'h00, 1'b0);
		push_pixel(8'hFF, 1'b0);
		push_pixel(8'h00, 1'b0);
		push_pixel(8'hFF, 1'b1);
		settle();

		// zero width acts as one column
		reg_write(bcr_pkg::REG_THRESHOLD, 12'h000);
		reg_write(bcr_pkg::REG_FRAME_WIDTH, 12'h000);
		repeat (3) push_pixel(8'h00, 1'b0);
		push_pixel(8'h00, 1'b1);
		settle();

		// oversize width clamps
		reg_write(bcr_pkg::REG_THRESHOLD, 12'h080);
		reg_write(bcr_pkg::REG_FRAME_WIDTH, 12'hFFF);
		push_pixel(8'h7F, 1'b0);
		push_pixel(8'h80, 1'b0);
		push_pixel(8'h81, 1'b0);
		push_pixel(8'hC8, 1'b1);
		settle();

		// spare indexes ignored, then width shrinks mid-row
		reg_write(bcr_pkg::REG_THRESHOLD, 12'h0C8);
		reg_write(bcr_pkg::REG_FRAME_WIDTH, 12'd3);
		reg_write(REG_SPARE_2, 12'hFFF);
		reg_write(REG_SPARE_3, 12'h000);
		push_pixel(8'hFF, 1'b0);
		repeat (3) push_pixel(8'h00, 1'b0);
		push_pixel(8'hFF, 1'b0);
		settle();
		reg_write(bcr_pkg::REG_FRAME_WIDTH, 12'd2);
		push_pixel(8'hFF, 1'b0);
		push_pixel(8'hFF, 1'b1);
		settle();

		for (int p = 0; p < 12; p++) begin
			idle_pct = (p < 4) ? 22 : ((p < 8) ? 86 : 0);
			random_config();
			fill_frames(90);
			settle();
		end

		// long frame: many rows at width one
		idle_pct = 0;
		reg_write(bcr_pkg::REG_THRESHOLD, 12'h0FF);
		push_pixel(8'h00, 1'b1);
		settle();
		reg_write(bcr_pkg::REG_THRESHOLD, 12'd100);
		reg_write(bcr_pkg::REG_FRAME_WIDTH, 12'd1);
		repeat (200) push_pixel(make_pixel(), 1'b0);
		push_pixel(make_pixel(), 1'b1);
		settle();

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : limit_p
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
